// ===== hdl/sha256_pkg.sv =====
// SHA-256 package: round constants, initial hash values, shared helpers.
// Used by every module of the stream hasher; no dependencies.
package sha256_pkg;

    localparam int WordWidth = 32;
    localparam int NumRounds = 64;
    localparam int BlockBytes = 64;

    typedef logic [WordWidth-1:0] word_t;

    // Sequencer state codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    // Compression control from sequencer to round unit
    typedef struct packed {
        logic start;
        logic init;
    } core_ctl_t;

    function automatic word_t initial_h(input logic [2:0] idx);
        word_t r;
        case (idx)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic word_t round_k(input logic [5:0] idx);
        word_t r;
        case (idx)
            6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
            6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
            6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
            6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
            6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (WordWidth - n));
    endfunction

endpackage

// ===== hdl/sha256_core.sv =====
// SHA-256 compression unit: one round per cycle over a rolling 16-word schedule.
// Depends on sha256_pkg.
module sha256_core
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  core_ctl_t   ctl,
    input  word_t       block_words [16],
    output logic        done,
    output word_t       hash_out [8]
);

    logic        busy_reg;
    logic [5:0]  round_reg;
    logic        fold_reg;
    word_t       h_reg [8];
    word_t       v_reg [8];
    word_t       w_reg [16];

    word_t w_cur, s0, s1, t1, t2, w_new;

    // Schedule word and round function for the current round
    always_comb begin
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        w_cur = (round_reg < 6'd16) ? w_reg[0] : w_new;
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
             + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + round_k(round_reg) + w_cur;
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // Control: run 64 rounds then fold into hash
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            fold_reg  <= 1'b0;
            round_reg <= '0;
        end else begin
            fold_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
            end else if (busy_reg) begin
                round_reg <= round_reg + 6'd1;
                if (round_reg == 6'(NumRounds - 1)) begin
                    busy_reg <= 1'b0;
                    fold_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load, round, fold
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= initial_h(3'(i));
        end else if (ctl.init) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= initial_h(3'(i));
        end else if (fold_reg) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
            for (int i = 0; i < 16; i++) w_reg[i] <= block_words[i];
        end else if (busy_reg) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_cur;
        end
    end

    assign done = fold_reg;
    always_comb for (int i = 0; i < 8; i++) hash_out[i] = h_reg[i];

endmodule

// ===== hdl/sha256_stream_hasher_unit.sv =====
// Top level of the SHA-256 stream hasher: byte buffer, padding sequencer, digest output.
// Depends on sha256_pkg and sha256_core.
//
// Takes a message one byte per transaction and emits the eight 32-bit SHA-256 digest
// words after the transaction marked end of message (tlast). A byte that completes a
// 64-byte block starts the shared round unit for 64 rounds, with load before and fold
// and return to idle after. Meanwhile s_axis_tready is low and no byte is taken. Ending
// a message adds one or two such compressions for padding, then eight output transactions.
module sha256_stream_hasher_unit
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] carries_byte
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_axis_tlast    // last_word
);

    logic [2:0]  state_reg;
    logic [5:0]  count_reg;
    logic [63:0] bits_reg;
    logic [63:0] len_reg;
    logic        end_reg;     // message ended, digest pending
    logic        padded_reg;  // first padding pass done
    logic        second_reg;  // padding needs a second block
    logic [2:0]  out_idx_reg;
    word_t       buf_reg [BlockBytes/4];
    word_t       block_words [16];
    word_t       hash_out [8];
    core_ctl_t   ctl;
    logic        done;

    sha256_core u_core (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl),
        .block_words(block_words), .done(done), .hash_out(hash_out)
    );

    // Big-endian words from the block buffer
    always_comb begin
        for (int i = 0; i < 16; i++)
            block_words[i] = buf_reg[i];
    end

    logic accept;
    logic [5:0] pos;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign pos = count_reg + 6'(s_axis_tuser);

    always_comb begin
        ctl.start = (state_reg == ST_LOAD);
        ctl.init  = (state_reg == ST_EMIT) && m_axis_tready && (out_idx_reg == 3'd7);
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            bits_reg    <= '0;
            end_reg     <= 1'b0;
            padded_reg  <= 1'b0;
            second_reg  <= 1'b0;
            out_idx_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_axis_tuser) count_reg <= pos;
                        end_reg <= s_axis_tlast;
                        if (s_axis_tuser && pos == 6'd0) begin
                            bits_reg  <= bits_reg + 64'd512;
                            state_reg <= ST_LOAD;
                        end else if (s_axis_tlast) begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_LOAD: state_reg <= ST_ROUND;
                ST_ROUND: if (done) state_reg <= ST_ADD;
                ST_ADD: begin
                    if (second_reg || (end_reg && !padded_reg)) begin
                        state_reg <= ST_PAD;
                    end else if (end_reg) begin
                        end_reg    <= 1'b0;
                        padded_reg <= 1'b0;
                        state_reg  <= ST_EMIT;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_PAD: begin
                    state_reg <= ST_LOAD;
                    if (!padded_reg) begin
                        padded_reg <= 1'b1;
                        second_reg <= (count_reg > 6'd55);
                    end else begin
                        second_reg <= 1'b0;
                    end
                end
                ST_EMIT: begin
                    if (m_axis_tready) begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == 3'd7) begin
                            state_reg <= ST_IDLE;
                            count_reg <= '0;
                            bits_reg  <= '0;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Buffer writes: data bytes and padding
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && accept) begin
            if (s_axis_tuser)
                buf_reg[count_reg[5:2]][{~count_reg[1:0], 3'd0} +: 8] <= s_axis_tdata;
            len_reg <= bits_reg + {55'd0, count_reg, 3'd0} + {60'd0, s_axis_tuser, 3'd0};
        end else if (state_reg == ST_PAD) begin
            if (!padded_reg) begin
                // First pad pass: 0x80 at count, zeros after, length when it fits
                for (int w = 0; w < 16; w++) begin
                    if (w >= 14 && count_reg <= 6'd55) begin
                        buf_reg[w] <= (w == 14) ? len_reg[63:32] : len_reg[31:0];
                    end else begin
                        for (int k = 0; k < 4; k++) begin
                            if (6'(4*w+k) == count_reg)
                                buf_reg[w][8*(3-k) +: 8] <= 8'h80;
                            else if (6'(4*w+k) > count_reg)
                                buf_reg[w][8*(3-k) +: 8] <= 8'h00;
                        end
                    end
                end
            end else begin
                // Extra block: zeros then length
                for (int w = 0; w < 14; w++) buf_reg[w] <= '0;
                buf_reg[14] <= len_reg[63:32];
                buf_reg[15] <= len_reg[31:0];
            end
        end
    end

    // Pad pass select: padded_reg marks the first pass done; second_reg routes
    // ST_ADD back to ST_PAD for the extra block

    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign m_axis_tdata  = {5'd0, out_idx_reg, hash_out[out_idx_reg]};
    assign m_axis_tlast  = (out_idx_reg == 3'd7);

endmodule
